// ===== sv/b2d_pkg.sv =====
// Shared constants and types for the binary to decimal ASCII digit converter.
// Used by the interfaces, the shift-add unit, the digit emitter, the top level and the checker.
package b2d_pkg;

  localparam int IN_WIDTH    = 64;
  localparam int VALUE_WIDTH = 64;
  localparam int MAX_DIGITS  = 20;
  localparam int CHAR_WIDTH  = 6;
  localparam int DIGIT_BITS  = 4 * MAX_DIGITS;
  localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH + 1);
  localparam int DIGIT_CNT_W = $clog2(MAX_DIGITS + 1);

  localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = CHAR_WIDTH'(48);
  localparam logic [CHAR_WIDTH-1:0] ASCII_NINE = CHAR_WIDTH'(57);

  typedef logic [3:0] digit_t;

  typedef enum logic [1:0] {
    D_IDLE,
    D_SHIFT,
    D_HOLD
  } dabble_state_t;

  typedef enum logic [1:0] {
    E_IDLE,
    E_SCAN,
    E_EMIT
  } emit_state_t;

  // Finished BCD word handed from the shift-add unit to the emitter.
  typedef struct packed {
    logic                  valid;
    logic [DIGIT_BITS-1:0] digits;
  } bcd_xfer_t;

endpackage

// ===== sv/b2d_if.sv =====
// Valid/ready channel interfaces for the input values and the output characters.
// Depends on b2d_pkg for field widths.
interface b2d_in_if;
  logic                         valid;
  logic                         ready;
  logic [b2d_pkg::IN_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface b2d_out_if;
  logic                           valid;
  logic                           ready;
  logic [b2d_pkg::CHAR_WIDTH-1:0] digit_char;
  logic                           last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink   (input valid, input digit_char, input last, output ready);
endinterface

// ===== sv/binary_to_decimal_ascii_digits.sv =====
// Top level of the binary to decimal ASCII digit converter.
// Depends on b2d_pkg, b2d_if, b2d_dabble and b2d_emit.
//
// Usage:
//   in_item takes one unsigned 64-bit value per item on a valid/ready handshake.
//   out_item gives its decimal digits as ASCII '0'..'9', most significant first,
//   leading zeros dropped, last high on the final digit; zero gives a single '0'.
//   Each value is taken, then shifted bit-serially into the BCD register, all 64
//   bits one at a time; the finished word is handed to the emitter, which skips
//   the leading zeros one at a time, leaves the scan, and then emits the digits
//   one at a time, waiting whenever the receiver stalls.
//   The shift-add unit takes a new value as soon as it has handed off its word
//   (accept, 64 shifts, hand-off), so the emitter's sweep of the 20 digits
//   overlaps the next value's shift loop.
//   Reset (rst_n low, synchronous) empties both units and drops any pending char.
//   A stalled receiver holds the registered char steady; the emitter waits, and
//   the shift-add unit then holds its finished word and stops taking input.
module binary_to_decimal_ascii_digits (
  input  logic       clk,
  input  logic       rst_n,
  b2d_in_if.sink     in_item,
  b2d_out_if.source  out_item
);

  b2d_pkg::bcd_xfer_t xfer;
  logic               xfer_ready;

  b2d_dabble u_dabble (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .xfer       (xfer),
    .xfer_ready (xfer_ready)
  );

  b2d_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .xfer       (xfer),
    .xfer_ready (xfer_ready),
    .out_item   (out_item)
  );

endmodule

// ===== sv/b2d_dabble.sv =====
// Bit-serial double dabble: shifts one value bit per cycle into a packed BCD register.
// Depends on b2d_pkg and b2d_in_if.
module b2d_dabble (
  input  logic               clk,
  input  logic               rst_n,
  b2d_in_if.sink             in_item,
  output b2d_pkg::bcd_xfer_t xfer,
  input  logic               xfer_ready
);

  b2d_pkg::dabble_state_t              state_r, state_nxt;
  logic [b2d_pkg::VALUE_WIDTH-1:0]     shift_r;
  logic [b2d_pkg::DIGIT_BITS-1:0]      bcd_r, bcd_nxt;
  logic [b2d_pkg::BIT_CNT_W-1:0]       cnt_r;
  b2d_pkg::digit_t                     adj [b2d_pkg::MAX_DIGITS];
  logic [b2d_pkg::MAX_DIGITS-1:0]      carry;
  logic                                accept;

  assign accept = in_item.valid && in_item.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      b2d_pkg::D_IDLE:  if (in_item.valid) state_nxt = b2d_pkg::D_SHIFT;
      b2d_pkg::D_SHIFT: if (cnt_r == b2d_pkg::BIT_CNT_W'(1)) state_nxt = b2d_pkg::D_HOLD;
      b2d_pkg::D_HOLD:  if (xfer_ready) state_nxt = b2d_pkg::D_IDLE;
      default:          state_nxt = b2d_pkg::D_IDLE;
    endcase
  end

  always_comb begin
    in_item.ready = (state_r == b2d_pkg::D_IDLE);
    xfer.valid    = (state_r == b2d_pkg::D_HOLD);
    xfer.digits   = bcd_r;
  end

  // Add 3 to every digit of 5 or more, then shift the whole word left by one.
  always_comb begin
    for (int d = 0; d < b2d_pkg::MAX_DIGITS; d++) begin
      adj[d] = (bcd_r[4*d +: 4] >= 4'd5) ? bcd_r[4*d +: 4] + 4'd3 : bcd_r[4*d +: 4];
    end
    carry[0] = shift_r[b2d_pkg::VALUE_WIDTH-1];
    for (int d = 1; d < b2d_pkg::MAX_DIGITS; d++) begin
      carry[d] = adj[d-1][3];
    end
    for (int d = 0; d < b2d_pkg::MAX_DIGITS; d++) begin
      bcd_nxt[4*d +: 4] = {adj[d][2:0], carry[d]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= b2d_pkg::D_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        cnt_r <= b2d_pkg::BIT_CNT_W'(b2d_pkg::VALUE_WIDTH);
      end else if (state_r == b2d_pkg::D_SHIFT) begin
        cnt_r <= cnt_r - b2d_pkg::BIT_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      shift_r <= in_item.value[b2d_pkg::VALUE_WIDTH-1:0];
      bcd_r   <= '0;
    end else if (state_r == b2d_pkg::D_SHIFT) begin
      shift_r <= shift_r << 1;
      bcd_r   <= bcd_nxt;
    end
  end

endmodule

// ===== sv/b2d_emit.sv =====
// Digit emitter: shifts BCD digits out from the top, drops leading zeros, registers each char.
// Depends on b2d_pkg and b2d_out_if.
module b2d_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  b2d_pkg::bcd_xfer_t xfer,
  output logic               xfer_ready,
  b2d_out_if.source          out_item
);

  b2d_pkg::emit_state_t              state_r, state_nxt;
  logic [b2d_pkg::DIGIT_BITS-1:0]    digits_r;
  logic [b2d_pkg::DIGIT_CNT_W-1:0]   rem_r;
  logic                              out_valid_r;
  logic [b2d_pkg::CHAR_WIDTH-1:0]    out_char_r;
  logic                              out_last_r;
  b2d_pkg::digit_t                   top;
  logic                              top_zero, final_digit, out_free, shift_en, emit_en;

  assign top         = digits_r[b2d_pkg::DIGIT_BITS-1 -: 4];
  assign top_zero    = (top == 4'd0);
  assign final_digit = (rem_r == b2d_pkg::DIGIT_CNT_W'(1));
  assign out_free    = !out_valid_r || out_item.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      b2d_pkg::E_IDLE: if (xfer.valid) state_nxt = b2d_pkg::E_SCAN;
      b2d_pkg::E_SCAN: if (!top_zero || final_digit) state_nxt = b2d_pkg::E_EMIT;
      b2d_pkg::E_EMIT: if (out_free && final_digit) state_nxt = b2d_pkg::E_IDLE;
      default:         state_nxt = b2d_pkg::E_IDLE;
    endcase
  end

  always_comb begin
    xfer_ready = (state_r == b2d_pkg::E_IDLE);
    emit_en    = (state_r == b2d_pkg::E_EMIT) && out_free;
    // Skip a leading zero unless it is the only digit left.
    shift_en   = emit_en || ((state_r == b2d_pkg::E_SCAN) && top_zero && !final_digit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= b2d_pkg::E_IDLE;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (xfer.valid && xfer_ready) begin
        rem_r <= b2d_pkg::DIGIT_CNT_W'(b2d_pkg::MAX_DIGITS);
      end else if (shift_en) begin
        rem_r <= rem_r - b2d_pkg::DIGIT_CNT_W'(1);
      end
      if (emit_en) begin
        out_valid_r <= 1'b1;
      end else if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer.valid && xfer_ready) begin
      digits_r <= xfer.digits;
    end else if (shift_en) begin
      digits_r <= digits_r << 4;
    end
    if (emit_en) begin
      out_char_r <= b2d_pkg::ASCII_ZERO | {{(b2d_pkg::CHAR_WIDTH-4){1'b0}}, top};
      out_last_r <= final_digit;
    end
  end

  assign out_item.valid      = out_valid_r;
  assign out_item.digit_char = out_char_r;
  assign out_item.last       = out_last_r;

endmodule

// ===== sv/b2d_checker.sv =====
// Port-level checker for the converter, bound to the top level.
// Depends on b2d_pkg.
module b2d_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [b2d_pkg::CHAR_WIDTH-1:0] out_digit_char,
  input logic                           out_last
);

  logic [b2d_pkg::DIGIT_CNT_W-1:0] run_cnt_r;

  // Count chars accepted in the current run.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_cnt_r <= '0;
    end else if (out_valid && out_ready) begin
      run_cnt_r <= out_last ? '0 : run_cnt_r + b2d_pkg::DIGIT_CNT_W'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digit_char) && $stable(out_last))
    else $error("output char changed while stalled");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_char >= b2d_pkg::ASCII_ZERO) &&
                  (out_digit_char <= b2d_pkg::ASCII_NINE))
    else $error("output char is not a decimal digit");

  a_no_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (run_cnt_r == '0) && (out_digit_char == b2d_pkg::ASCII_ZERO) |-> out_last)
    else $error("leading zero emitted");

  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |->
      run_cnt_r < b2d_pkg::DIGIT_CNT_W'(b2d_pkg::MAX_DIGITS - 1))
    else $error("run longer than the digit capacity");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again during conversion");

endmodule

bind binary_to_decimal_ascii_digits b2d_checker u_b2d_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_item.valid),
  .in_ready       (in_item.ready),
  .out_valid      (out_item.valid),
  .out_ready      (out_item.ready),
  .out_digit_char (out_item.digit_char),
  .out_last       (out_item.last)
);
